// ===== design/trimmed_sum_three_low_three_high_top_macros.svh =====
// Assertion macros for the trimmed-sum filter.
// Used by the top level; they need clk and arst_n in scope.
`ifndef TRIMMED_SUM_THREE_LOW_THREE_HIGH_TOP_MACROS_SVH
`define TRIMMED_SUM_THREE_LOW_THREE_HIGH_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TSUM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsum assertion failed");

// next-cycle implication
`define TSUM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsum assertion failed");

`else

`define TSUM_ASSERT_NOW(label, ante, cons)
`define TSUM_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== design/tsum_pkg.sv =====
// Shared widths and constants for the trimmed-sum filter.
// No dependencies; imported by the interfaces and the top level.
`timescale 1ns / 1ps

package tsum_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int SUM_W      = 48;
	localparam int WARMUP_W   = 4;
	localparam int COUNT_BITS = 16;
	localparam int TRIM_W     = SAMPLE_W + 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(6);
	localparam logic [WARMUP_W-1:0]   WARMUP_RST = WARMUP_W'(2);

endpackage

// ===== design/tsum_sample_if.sv =====
// Sample channel: valid/ready handshake carrying one sample and its last flag.
// Depends on tsum_pkg.
`timescale 1ns / 1ps

interface tsum_sample_if import tsum_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);

endinterface

// ===== design/tsum_result_if.sv =====
// Result channel: valid/ready handshake carrying the trimmed sum and too-few flag.
// Depends on tsum_pkg.
`timescale 1ns / 1ps

interface tsum_result_if import tsum_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] trimmed_sum;
	logic             too_few;

	modport source (output valid, output trimmed_sum, output too_few, input ready);
	modport sink (input valid, input trimmed_sum, input too_few, output ready);

endinterface

// ===== design/trimmed_sum_three_low_three_high_top.sv =====
// Channel   | Dir | Payload                      | Handshake
// samples   | in  | sample[31:0], last           | valid/ready
// results   | out | trimmed_sum[47:0], too_few   | valid/ready
// cfg       | in  | cfg_wdata[3:0] (warm-up)     | cfg_we, no wait
//
// One sample per cycle sustained unless a result stall backs up; once a run's last
// sample is accepted, its result goes through snapshot, trim and output registers.
// Four-stage valid/ready pipeline; under a result stall up to three closed runs
// wait in the snapshot, trim and output registers, then a last sample holds in
// the input register and the sample input stalls behind it.
// arst_n clears all control state, the run state and sets warm-up to 2.
// Depends on tsum_pkg, tsum_sample_if, tsum_result_if and the macros header.
`timescale 1ns / 1ps
`include "trimmed_sum_three_low_three_high_top_macros.svh"

module trimmed_sum_three_low_three_high_top import tsum_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	tsum_sample_if.sink         samples,
	tsum_result_if.source       results,
	input  logic                cfg_we,
	input  logic [WARMUP_W-1:0] cfg_wdata
);

	// configuration register
	logic [WARMUP_W-1:0] warmup_q;

	// input register
	logic                v_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                last_s1;

	// run state
	logic [WARMUP_W-1:0]   skip_q;
	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [SAMPLE_W-1:0]   low_q  [3];
	logic [SAMPLE_W-1:0]   high_q [3];

	// next run state
	logic                  count_en;
	logic [SUM_W-1:0]      sum_nxt;
	logic [COUNT_BITS-1:0] count_nxt;
	logic [SAMPLE_W-1:0]   low_nxt  [3];
	logic [SAMPLE_W-1:0]   high_nxt [3];

	// end-of-run snapshot
	logic                v_s2;
	logic [SUM_W-1:0]    sum_s2;
	logic [SAMPLE_W-1:0] low_s2  [3];
	logic [SAMPLE_W-1:0] high_s2 [3];
	logic                few_s2;

	// partial trim sums
	logic              v_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic [TRIM_W-1:0] lsum_s3;
	logic [TRIM_W-1:0] hsum_s3;
	logic              few_s3;

	// output register
	logic             out_v_q;
	logic [SUM_W-1:0] out_sum_q;
	logic             out_few_q;

	// stage handshakes
	logic adv1, adv2, adv3;
	logic rdy_s2;

	assign adv3   = v_s3 && (!out_v_q || results.ready);
	assign adv2   = v_s2 && (!v_s3 || adv3);
	assign rdy_s2 = !v_s2 || adv2;
	assign adv1   = v_s1 && (!last_s1 || rdy_s2);

	assign samples.ready = !v_s1 || adv1;

	// warm-up register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= WARMUP_RST;
		end else if (cfg_we) begin
			warmup_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (samples.ready) begin
			v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			sample_s1 <= samples.sample;
			last_s1   <= samples.last;
		end
	end

	// sum, saturating count and three-deep insert for both extremes
	always_comb begin
		count_en  = !(skip_q < warmup_q);
		sum_nxt   = sum_q;
		count_nxt = count_q;
		low_nxt   = low_q;
		high_nxt  = high_q;
		if (count_en) begin
			sum_nxt = sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, sample_s1};
			if (count_q < COUNT_MAX) begin
				count_nxt = count_q + COUNT_BITS'(1);
			end
			if (sample_s1 < low_q[0]) begin
				low_nxt[0] = sample_s1;
				low_nxt[1] = low_q[0];
				low_nxt[2] = low_q[1];
			end else if (sample_s1 < low_q[1]) begin
				low_nxt[1] = sample_s1;
				low_nxt[2] = low_q[1];
			end else if (sample_s1 < low_q[2]) begin
				low_nxt[2] = sample_s1;
			end
			if (sample_s1 > high_q[0]) begin
				high_nxt[0] = sample_s1;
				high_nxt[1] = high_q[0];
				high_nxt[2] = high_q[1];
			end else if (sample_s1 > high_q[1]) begin
				high_nxt[1] = sample_s1;
				high_nxt[2] = high_q[1];
			end else if (sample_s1 > high_q[2]) begin
				high_nxt[2] = sample_s1;
			end
		end
	end

	// run state: cleared after the last sample of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
			for (int i = 0; i < 3; i++) begin
				low_q[i]  <= '1;
				high_q[i] <= '0;
			end
		end else if (adv1) begin
			if (last_s1) begin
				skip_q  <= '0;
				sum_q   <= '0;
				count_q <= '0;
				for (int i = 0; i < 3; i++) begin
					low_q[i]  <= '1;
					high_q[i] <= '0;
				end
			end else begin
				if (!count_en) begin
					skip_q <= skip_q + WARMUP_W'(1);
				end
				sum_q   <= sum_nxt;
				count_q <= count_nxt;
				low_q   <= low_nxt;
				high_q  <= high_nxt;
			end
		end
	end

	// snapshot of the closing run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv1 && last_s1) begin
			v_s2 <= 1'b1;
		end else if (adv2) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && last_s1) begin
			sum_s2  <= sum_nxt;
			low_s2  <= low_nxt;
			high_s2 <= high_nxt;
			few_s2  <= count_nxt < MIN_COUNT;
		end
	end

	// add up the three lowest and the three highest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv2) begin
			v_s3 <= 1'b1;
		end else if (adv3) begin
			v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			sum_s3  <= sum_s2;
			lsum_s3 <= TRIM_W'(low_s2[0]) + TRIM_W'(low_s2[1]) + TRIM_W'(low_s2[2]);
			hsum_s3 <= TRIM_W'(high_s2[0]) + TRIM_W'(high_s2[1]) + TRIM_W'(high_s2[2]);
			few_s3  <= few_s2;
		end
	end

	// output register: sum minus the six trimmed values, zero when too few
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv3) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			out_few_q <= few_s3;
			if (few_s3) begin
				out_sum_q <= '0;
			end else begin
				out_sum_q <= sum_s3 - {{(SUM_W-TRIM_W){1'b0}}, lsum_s3}
					- {{(SUM_W-TRIM_W){1'b0}}, hsum_s3};
			end
		end
	end

	assign results.valid       = out_v_q;
	assign results.trimmed_sum = out_sum_q;
	assign results.too_few     = out_few_q;

	// checks
	`TSUM_ASSERT_NOW(a_low_sorted, 1'b1, low_q[0] <= low_q[1] && low_q[1] <= low_q[2])
	`TSUM_ASSERT_NOW(a_high_sorted, 1'b1, high_q[0] >= high_q[1] && high_q[1] >= high_q[2])
	`TSUM_ASSERT_NXT(a_run_cleared, adv1 && last_s1, sum_q == '0 && count_q == '0 && skip_q == '0)
	`TSUM_ASSERT_NOW(a_few_zero, out_v_q && out_few_q, out_sum_q == '0)

endmodule

// ===== tb/trimmed_sum_three_low_three_high_top_tb.sv =====
// Self-checking bench for the trimmed-sum filter: sends runs of samples under
// random stalls, predicts each run's trimmed sum and too-few flag, checks results.
// Depends on tsum_pkg, tsum_sample_if, tsum_result_if and the filter top level.
`timescale 1ns / 1ps

module trimmed_sum_three_low_three_high_top_tb;
	import tsum_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [SUM_W-1:0] trimmed_sum;
		logic             too_few;
	} run_total_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [WARMUP_W-1:0] cfg_wdata;

	tsum_sample_if samples_ch ();
	tsum_result_if results_ch ();

	trimmed_sum_three_low_three_high_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_ch),
		.results  (results_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// run state mirrored by the predictor
	logic [WARMUP_W-1:0]   warmup_len = WARMUP_RST;
	logic [WARMUP_W-1:0]   warmup_seen;
	logic [SUM_W-1:0]      run_sum;
	logic [COUNT_BITS-1:0] run_count;
	logic [SAMPLE_W-1:0]   low3 [3];
	logic [SAMPLE_W-1:0]   high3 [3];

	run_total_t run_totals_due [$];

	int cycle_count    = 0;
	int mismatch_count = 0;
	int items_sent     = 0;
	int send_gap_pct   = 33;
	int recv_stall_pct = 57;
	int hold_until     = 0;

	// clock
	always #CLK_HALF clk = ~clk;

	// cycle counter and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("trimmed_sum_three_low_three_high_top_tb: errors");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off until hold_until
	always @(negedge clk)
		results_ch.ready <= (cycle_count >= hold_until) &&
			($urandom_range(99, 0) >= recv_stall_pct);

	task automatic flag_mismatch(input string what, input logic [SUM_W-1:0] got,
			input logic [SUM_W-1:0] want);
		mismatch_count++;
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	function automatic void clear_run_state();
		warmup_seen = '0;
		run_sum     = '0;
		run_count   = '0;
		for (int k = 0; k < 3; k++) begin
			low3[k]  = '1;
			high3[k] = '0;
		end
	endfunction

	// predictor: fold one accepted request into the run, close it on last
	function automatic void take_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
		logic [SUM_W-1:0] trim;
		run_total_t       total;
		if (warmup_seen < warmup_len) begin
			warmup_seen++;
		end else begin
			run_sum = run_sum + SUM_W'(value);
			if (run_count != COUNT_MAX)
				run_count++;
			// three smallest, ascending; equal values take their own slot
			if (value < low3[0]) begin
				low3[2] = low3[1];
				low3[1] = low3[0];
				low3[0] = value;
			end else if (value < low3[1]) begin
				low3[2] = low3[1];
				low3[1] = value;
			end else if (value < low3[2]) begin
				low3[2] = value;
			end
			// three largest, descending
			if (value > high3[0]) begin
				high3[2] = high3[1];
				high3[1] = high3[0];
				high3[0] = value;
			end else if (value > high3[1]) begin
				high3[2] = high3[1];
				high3[1] = value;
			end else if (value > high3[2]) begin
				high3[2] = value;
			end
		end
		if (is_last) begin
			if (run_count < MIN_COUNT) begin
				total.trimmed_sum = '0;
				total.too_few     = 1'b1;
			end else begin
				trim = SUM_W'(low3[0]) + SUM_W'(low3[1]) + SUM_W'(low3[2]) +
					SUM_W'(high3[0]) + SUM_W'(high3[1]) + SUM_W'(high3[2]);
				total.trimmed_sum = run_sum - trim;
				total.too_few     = 1'b0;
			end
			run_totals_due.push_back(total);
			clear_run_state();
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		run_total_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (run_totals_due.size() == 0) begin
				flag_mismatch("result with no closed run", results_ch.trimmed_sum, '0);
			end else begin
				want = run_totals_due.pop_front();
				if (results_ch.trimmed_sum !== want.trimmed_sum)
					flag_mismatch("trimmed_sum", results_ch.trimmed_sum, want.trimmed_sum);
				if (results_ch.too_few !== want.too_few)
					flag_mismatch("too_few", SUM_W'(results_ch.too_few), SUM_W'(want.too_few));
			end
		end
	end

	// send one request; entered and left at a falling edge, valid stays high
	task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
		while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
			samples_ch.valid <= 1'b0;
			@(negedge clk);
		end
		samples_ch.valid  <= 1'b1;
		samples_ch.sample <= value;
		samples_ch.last   <= is_last;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		take_sample(value, is_last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_list(input logic [SAMPLE_W-1:0] values [$]);
		for (int k = 0; k < values.size(); k++)
			send_sample(values[k], k == values.size() - 1);
	endtask

	// stop offering and wait until every closed run has reported
	task automatic wait_results_drained();
		samples_ch.valid <= 1'b0;
		while (run_totals_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_warmup(input logic [WARMUP_W-1:0] len);
		wait_results_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we      <= 1'b0;
		warmup_len = len;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9, 0))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(7, 0);
			4: return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFF0);
			default: return $urandom();
		endcase
	endfunction

	// one run with random length; a few close inside the warm-up
	task automatic random_run();
		int shape;
		int counted;
		int total;
		shape = $urandom_range(99, 0);
		if (warmup_len != 0 && shape < 5) begin
			total = $urandom_range(int'(warmup_len), 1);
		end else begin
			if (shape < 25)
				counted = $urandom_range(5, 0);
			else if (shape < 95)
				counted = $urandom_range(20, 6);
			else
				counted = $urandom_range(60, 21);
			total = int'(warmup_len) + counted;
			if (total == 0)
				total = 1;
		end
		for (int k = 0; k < total; k++)
			send_sample(pick_sample(), k == total - 1);
	endtask

	// extremes, ties, too few samples, last inside warm-up (warm-up at reset value)
	task automatic test_directed();
		logic [SAMPLE_W-1:0] vals [$];
		vals = '{'1, '1, '0, '1, 32'd1, 32'hFFFF_FFFE, '0, '1, 32'd7};
		send_list(vals);
		vals = '{32'd123};
		send_list(vals);
		vals = '{32'd9, 32'd9, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFF};
		send_list(vals);
		vals = '{'0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_list(vals);
		wait_results_drained();
	endtask

	// warm-up register at both ends and at random values
	task automatic test_warmup_settings();
		logic [SAMPLE_W-1:0] vals [$];
		send_gap_pct   = 33;
		recv_stall_pct = 57;
		set_warmup('0);
		vals = '{32'd10, 32'd20, 32'd30, 32'd40, 32'd50, 32'd60};
		send_list(vals);
		vals = '{32'd5};
		send_list(vals);
		random_run();
		set_warmup('1);
		repeat (3) random_run();
		for (int k = 0; k < 10; k++)
			send_sample(pick_sample(), k == 9);
		repeat (3) begin
			set_warmup(WARMUP_W'($urandom_range(14, 1)));
			repeat (2) random_run();
		end
	endtask

	// three idle patterns, warm-up changed between blocks of runs
	task automatic test_random_traffic();
		int start;
		for (int phase = 0; phase < 3; phase++) begin
			wait_results_drained();
			case (phase)
				0: begin
					send_gap_pct   = 33;
					recv_stall_pct = 57;
				end
				1: begin
					send_gap_pct   = 57;
					recv_stall_pct = 33;
				end
				default: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				if ($urandom_range(3, 0) == 0)
					set_warmup(WARMUP_W'($urandom_range(15, 0)));
				else
					set_warmup(WARMUP_W'($urandom_range(2, 0)));
				start = items_sent;
				while (items_sent - start < 40)
					random_run();
			end
		end
	endtask

	// receiver holds off while short runs keep coming, so the block backs up
	task automatic test_backpressure();
		wait_results_drained();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		set_warmup('0);
		hold_until = cycle_count + 300;
		repeat (30) begin
			for (int k = 0; k < 7; k++)
				send_sample(pick_sample(), k == 6);
		end
		wait_results_drained();
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		samples_ch.valid  = 1'b0;
		samples_ch.sample = '0;
		samples_ch.last   = 1'b0;
		clear_run_state();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_warmup_settings();
		test_random_traffic();
		test_backpressure();
		wait_results_drained();

		if (mismatch_count == 0)
			$display("trimmed_sum_three_low_three_high_top_tb: clean");
		else
			$display("trimmed_sum_three_low_three_high_top_tb: errors");
		$finish;
	end

endmodule
